/* rtl/ogrt_pkg.sv */
// ----------------------------------------------------------------------------
// Occupancy grid ray trace package
// Grid geometry, cell codes and the memory request bundle shared by the grid
// store and the sequencer, and the small helper functions of the sequencer.
// ----------------------------------------------------------------------------
package ogrt_pkg;

  localparam int GRID_W = 256;
  localparam int GRID_H = 256;
  localparam int DEPTH  = GRID_W * GRID_H;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);
  localparam int CW     = 13;
  localparam int WW     = 14;

  localparam logic MODE_TRACE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [1:0] {
    CELL_UNKNOWN,
    CELL_FREE,
    CELL_OCCUPIED
  } cell_e;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    cell_e         data;
  } grid_req_t;

  function automatic logic cell_in_grid(coord_t x, coord_t y);
    logic x_ok;
    logic y_ok;
    x_ok = !x[CW-1] && ({1'b0, x[CW-2:0]} < CW'(GRID_W));
    y_ok = !y[CW-1] && ({1'b0, y[CW-2:0]} < CW'(GRID_H));
    return x_ok && y_ok;
  endfunction

  function automatic logic [AW-1:0] cell_addr(coord_t x, coord_t y);
    return AW'(y[YW-1:0]) * AW'(GRID_W) + AW'(x[XW-1:0]);
  endfunction

endpackage

/* rtl/ogrt_grid.sv */
// ----------------------------------------------------------------------------
// Occupancy grid store
// Single-port grid memory of two-bit cells with one write or one read per
// cycle and registered read data.
// ----------------------------------------------------------------------------
module ogrt_grid (
  input  logic               clk_i,
  input  ogrt_pkg::grid_req_t req_i,
  output logic [1:0]          rd_data_o
);
  import ogrt_pkg::*;

  logic [1:0] grid_mem [DEPTH];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      grid_mem[req_i.addr] <= req_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= grid_mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/occupancy_grid_ray_trace.sv */
// ----------------------------------------------------------------------------
// Occupancy grid ray trace
// A ray beat walks the Bresenham line one cell per cycle and marks in-grid
// cells free, then marks an in-grid endpoint occupied. A read beat returns
// the status of one cell.
// ----------------------------------------------------------------------------
// After reset the grid is cleared one cell per cycle with in_ready_o low.
// Control state is cleared by rst_ni.
// A ray passes the setup, walk, mark and done states before its result is
// registered, the walk using the single grid write port once per line cell; a
// read passes the read-request and done states. A beat is accepted only in
// idle, even while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_trace (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic signed [12:0]        start_x_i,
  input  logic signed [12:0]        start_y_i,
  input  logic signed [12:0]        end_x_i,
  input  logic signed [12:0]        end_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                cell_status_o,
  output logic                      in_grid_o,
  output logic [13:0]               cells_walked_o
);
  import ogrt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_RDREQ = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state_q;
  logic [AW-1:0]       clr_cnt_q;
  logic                mode_q;
  coord_t              cx_q;
  coord_t              cy_q;
  coord_t              x1_q;
  coord_t              y1_q;
  logic signed [14:0]  dx_q;
  logic signed [14:0]  dy_q;
  logic                sx_neg_q;
  logic                sy_neg_q;
  logic signed [16:0]  err_q;
  logic [WW-1:0]       walked_q;

  logic                out_valid_q;
  logic [1:0]          cell_status_q;
  logic                in_grid_q;
  logic [WW-1:0]       cells_walked_q;

  grid_req_t           grid_req;
  logic [1:0]          rd_data;

  logic                accept;
  logic                cur_in_grid;
  logic                at_end;
  logic                out_free;
  logic signed [14:0]  dx_raw;
  logic signed [14:0]  dy_raw;
  logic signed [14:0]  dx_abs;
  logic signed [14:0]  dy_neg;
  logic signed [17:0]  e2;
  logic signed [17:0]  dx_ext;
  logic signed [17:0]  dy_ext;
  logic                step_x;
  logic                step_y;
  logic signed [16:0]  err_next;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cur_in_grid = cell_in_grid(cx_q, cy_q);
  assign at_end      = (cx_q == x1_q) && (cy_q == y1_q);
  assign out_free    = !out_valid_q || out_ready_i;

  assign dx_raw = $signed({{2{x1_q[CW-1]}}, x1_q}) - $signed({{2{cx_q[CW-1]}}, cx_q});
  assign dy_raw = $signed({{2{y1_q[CW-1]}}, y1_q}) - $signed({{2{cy_q[CW-1]}}, cy_q});
  assign dx_abs = dx_raw[14] ? -dx_raw : dx_raw;
  assign dy_neg = dy_raw[14] ? dy_raw : -dy_raw;

  assign e2       = $signed({err_q, 1'b0});
  assign dx_ext   = $signed({{3{dx_q[14]}}, dx_q});
  assign dy_ext   = $signed({{3{dy_q[14]}}, dy_q});
  assign step_x   = (e2 >= dy_ext);
  assign step_y   = (e2 <= dx_ext);
  assign err_next = err_q
                  + (step_x ? $signed({{2{dy_q[14]}}, dy_q}) : 17'sd0)
                  + (step_y ? $signed({{2{dx_q[14]}}, dx_q}) : 17'sd0);

  always_comb begin
    grid_req      = '0;
    grid_req.addr = cell_addr(cx_q, cy_q);
    grid_req.data = CELL_UNKNOWN;
    case (state_q)
      S_CLEAR: begin
        grid_req.we   = 1'b1;
        grid_req.addr = clr_cnt_q;
      end
      S_WALK: begin
        grid_req.we   = cur_in_grid;
        grid_req.data = CELL_FREE;
      end
      S_MARK: begin
        grid_req.we   = cur_in_grid;
        grid_req.data = CELL_OCCUPIED;
      end
      S_RDREQ: begin
        grid_req.re = 1'b1;
      end
      default: begin
        grid_req.we = 1'b0;
      end
    endcase
  end

  ogrt_grid u_grid (
    .clk_i     (clk_i),
    .req_i     (grid_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= (mode_i == MODE_READ) ? S_RDREQ : S_SETUP;
          end
        end
        S_SETUP: state_q <= S_WALK;
        S_WALK: begin
          if (at_end) begin
            state_q <= S_MARK;
          end
        end
        S_MARK:  state_q <= S_DONE;
        S_RDREQ: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      cx_q     <= start_x_i;
      cy_q     <= start_y_i;
      x1_q     <= end_x_i;
      y1_q     <= end_y_i;
      walked_q <= '0;
    end
    if (state_q == S_SETUP) begin
      dx_q     <= dx_abs;
      dy_q     <= dy_neg;
      sx_neg_q <= !dx_raw[14] && (dx_raw == 15'sd0) ? 1'b1 : dx_raw[14];
      sy_neg_q <= !dy_raw[14] && (dy_raw == 15'sd0) ? 1'b1 : dy_raw[14];
      err_q    <= $signed({{2{dx_abs[14]}}, dx_abs}) + $signed({{2{dy_neg[14]}}, dy_neg});
    end
    if (state_q == S_WALK) begin
      walked_q <= walked_q + WW'(1);
      if (!at_end) begin
        err_q <= err_next;
        if (step_x) begin
          cx_q <= sx_neg_q ? cx_q - CW'(1) : cx_q + CW'(1);
        end
        if (step_y) begin
          cy_q <= sy_neg_q ? cy_q - CW'(1) : cy_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      cell_status_q  <= (mode_q == MODE_READ && cur_in_grid) ? rd_data : CELL_UNKNOWN;
      in_grid_q      <= cur_in_grid;
      cells_walked_q <= walked_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_status_o  = cell_status_q;
  assign in_grid_o      = in_grid_q;
  assign cells_walked_o = cells_walked_q;

  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !grid_req.we)
    else $error("Grid write while the block is ready.");

  a_status_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_status_o != CELL_UNKNOWN) |-> (cells_walked_o == '0) && in_grid_o)
    else $error("Nonzero cell status on a ray result or an off-grid read.");

  a_walk_ends_in_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) && at_end |=> (state_q == S_MARK) && (walked_q != '0))
    else $error("Line walk did not end with an endpoint mark.");

endmodule
